// File: sv/aus_pkg.sv
package aus_pkg;

    localparam int DATA_W     = 8;
    localparam int LEN_W      = 24;
    localparam int NUM_W      = 24;
    localparam int TS_W       = 32;
    localparam int PERIOD_W   = 20;
    localparam int PROD_W     = NUM_W + PERIOD_W;
    localparam int WIN_DEPTH  = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // timestamp product split for the divide by 1000
    localparam int PROD_LO_W  = 22;
    localparam int PROD_HI_W  = PROD_W - PROD_LO_W;
    localparam int QHI_W      = 13;
    localparam int QLO_W      = 22;
    localparam int REM_W      = 10;

    localparam logic [2:0]          FILL_MAX     = 3'd6;
    localparam logic [2:0]          WIN_READY    = 3'd5;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd33366;
    localparam logic [DATA_W-1:0]   NAL_TYPE_MASK = 8'h0f;
    localparam logic [LEN_W-1:0]    LEN_OUT_MAX  = 24'hFFFFFF;
    localparam logic [REM_W-1:0]    DIV_BY       = 10'd1000;
    // floor(2^32 / 1000) and floor(2^41 / 1000)
    localparam logic [22:0]         RECIP_HI     = 23'd4294967;
    localparam logic [31:0]         RECIP_LO     = 32'd2199023255;

    localparam logic [0:0]          REG_FRAME_PERIOD = 1'b0;

    typedef struct packed {
        logic              frame_valid;
        logic [LEN_W-1:0]  frame_length;
        logic [NUM_W-1:0]  frame_number;
        logic              end_of_stream;
    } result_info_t;

    function automatic logic qualifies(input logic [DATA_W-1:0] hdr,
                                       input logic [DATA_W-1:0] nxt);
        logic [DATA_W-1:0] t;
        t = hdr & NAL_TYPE_MASK;
        return (t inside {[8'd1:8'd5]}) && nxt[DATA_W-1];
    endfunction

endpackage

// File: sv/aus_cfg.sv
module aus_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [aus_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [aus_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [aus_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    output logic [aus_pkg::PERIOD_W-1:0]         frame_period_us
);

    logic [aus_pkg::PERIOD_W-1:0] period_reg;
    logic [0:0]                   reg_index;
    logic                         wr_en;

    assign reg_index = paddr[aus_pkg::APB_ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= aus_pkg::PERIOD_RESET;
        end else if (wr_en && (reg_index == aus_pkg::REG_FRAME_PERIOD)) begin
            period_reg <= pwdata[aus_pkg::PERIOD_W-1:0];
        end
    end

    always_comb begin
        case (reg_index)
            aus_pkg::REG_FRAME_PERIOD: prdata = aus_pkg::APB_DATA_W'(period_reg);
            default:                   prdata = '0;
        endcase
    end

    assign frame_period_us = period_reg;

endmodule

// File: sv/aus_scan.sv
module aus_scan #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [aus_pkg::DATA_W-1:0]         s_data_byte,
    input  logic                               s_last,
    input  logic [aus_pkg::PERIOD_W-1:0]       frame_period_us,
    output logic                               out_valid,
    input  logic                               out_ready,
    output aus_pkg::result_info_t              out_info,
    output logic [aus_pkg::PROD_W-1:0]         out_prod
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic                          in_valid_reg;
    logic [aus_pkg::DATA_W-1:0]    in_data_reg;
    logic                          in_last_reg;

    logic [aus_pkg::DATA_W-1:0]    win_reg  [aus_pkg::WIN_DEPTH];
    logic [aus_pkg::DATA_W-1:0]    win_next [aus_pkg::WIN_DEPTH];
    logic [2:0]                    fill_reg, fill_next;
    logic [LENGTH_BITS-1:0]        bss_reg, bss_next;
    logic                          open_reg, open_next;
    logic [1:0]                    skip_reg, skip_next;
    logic [aus_pkg::NUM_W-1:0]     counter_reg, counter_next;
    logic                          prev_scanned_reg, prev_scanned_next;
    logic [aus_pkg::PROD_W-1:0]    prod_reg;

    logic                          fire;
    logic                          emit;
    logic                          four;
    logic [LENGTH_BITS-1:0]        bss_inc;
    logic [LENGTH_BITS-1:0]        len_sel;
    logic [31:0]                   len_wide;
    logic [aus_pkg::LEN_W-1:0]     len_sat;

    assign fire    = in_valid_reg && out_ready;
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last;
        end
    end

    // counter * period, registered from counter_reg; boundaries are at least three bytes apart
    always_ff @(posedge aclk) begin
        prod_reg <= aus_pkg::PROD_W'(counter_reg) * aus_pkg::PROD_W'(frame_period_us);
    end

    always_comb begin
        for (int i = 0; i < aus_pkg::WIN_DEPTH - 1; i++) begin
            win_next[i] = win_reg[i+1];
        end
        win_next[aus_pkg::WIN_DEPTH-1] = in_data_reg;
        fill_next         = (fill_reg < aus_pkg::FILL_MAX) ? fill_reg + 3'd1 : aus_pkg::FILL_MAX;
        bss_next          = bss_reg;
        open_next         = open_reg;
        skip_next         = skip_reg;
        counter_next      = counter_reg;
        prev_scanned_next = prev_scanned_reg;
        emit              = 1'b0;
        four              = 1'b0;
        bss_inc           = bss_reg;
        len_sel           = bss_reg;

        if (fill_next >= aus_pkg::WIN_READY) begin
            if (open_reg && (bss_reg != LEN_MAX)) begin
                bss_inc = bss_reg + LENGTH_BITS'(1);
            end
            bss_next = bss_inc;
            len_sel  = bss_inc;
            if (skip_reg != 2'd0) begin
                skip_next = skip_reg - 2'd1;
            end else if ((win_reg[1] == 8'd0) && (win_reg[2] == 8'd0) &&
                         (win_reg[3] == 8'd1)) begin
                four = prev_scanned_reg && (fill_next >= aus_pkg::FILL_MAX) &&
                       (win_reg[0] == 8'd0);
                if (!open_reg) begin
                    open_next = 1'b1;
                    bss_next  = LENGTH_BITS'(four);
                end else if (aus_pkg::qualifies(win_reg[4], in_data_reg)) begin
                    if (four && (bss_inc != LEN_MAX)) begin
                        len_sel = bss_inc - LENGTH_BITS'(1);
                    end
                    emit         = 1'b1;
                    counter_next = counter_reg + aus_pkg::NUM_W'(1);
                    bss_next     = LENGTH_BITS'(four);
                end
                skip_next = four ? 2'd1 : 2'd2;
            end
            prev_scanned_next = (skip_reg == 2'd0);
        end

        if (in_last_reg) begin
            for (int i = 0; i < aus_pkg::WIN_DEPTH; i++) begin
                win_next[i] = '0;
            end
            fill_next         = '0;
            bss_next          = '0;
            open_next         = 1'b0;
            skip_next         = '0;
            counter_next      = '0;
            prev_scanned_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < aus_pkg::WIN_DEPTH; i++) begin
                win_reg[i] <= '0;
            end
            fill_reg         <= '0;
            bss_reg          <= '0;
            open_reg         <= 1'b0;
            skip_reg         <= '0;
            counter_reg      <= '0;
            prev_scanned_reg <= 1'b0;
        end else if (fire) begin
            win_reg          <= win_next;
            fill_reg         <= fill_next;
            bss_reg          <= bss_next;
            open_reg         <= open_next;
            skip_reg         <= skip_next;
            counter_reg      <= counter_next;
            prev_scanned_reg <= prev_scanned_next;
        end
    end

    assign len_wide = 32'(len_sel);
    assign len_sat  = (len_wide > 32'(aus_pkg::LEN_OUT_MAX)) ? aus_pkg::LEN_OUT_MAX
                                                            : len_wide[aus_pkg::LEN_W-1:0];

    always_comb begin
        out_info.frame_valid   = emit;
        out_info.frame_length  = emit ? len_sat : '0;
        out_info.frame_number  = emit ? counter_reg : '0;
        out_info.end_of_stream = in_last_reg;
    end

    assign out_valid = in_valid_reg && (emit || in_last_reg);
    assign out_prod  = prod_reg;

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last_reg |=> !open_reg && (counter_reg == '0) && (fill_reg == '0))
        else $error("stream state not cleared after last byte");

    a_emit_needs_open: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && emit |-> open_reg && (skip_reg == 2'd0))
        else $error("frame boundary without an open frame");

    a_emit_skips: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && emit && !in_last_reg |=> (skip_reg != 2'd0) && ($past(counter_reg) + 24'd1 == counter_reg))
        else $error("boundary did not advance skip and frame counter");
`endif

endmodule

// File: sv/aus_ts_pipe.sv
module aus_ts_pipe (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  aus_pkg::result_info_t              in_info,
    input  logic [aus_pkg::PROD_W-1:0]         in_prod,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_frame_valid,
    output logic [aus_pkg::LEN_W-1:0]          m_frame_length,
    output logic [aus_pkg::NUM_W-1:0]          m_frame_number,
    output logic [aus_pkg::TS_W-1:0]           m_timestamp_ms,
    output logic                               m_end_of_stream
);

    logic c_valid_reg, d_valid_reg, e_valid_reg, f_valid_reg;
    logic en_c, en_d, en_e, en_f;

    aus_pkg::result_info_t            c_info_reg, d_info_reg, e_info_reg, f_info_reg;
    logic [aus_pkg::QHI_W-1:0]        c_est_reg;
    logic [aus_pkg::PROD_HI_W-1:0]    c_xh_reg;
    logic [aus_pkg::PROD_LO_W-1:0]    c_xl_reg;
    logic [aus_pkg::QHI_W-1:0]        d_qh_reg, e_qh_reg;
    logic [31:0]                      d_v_reg, e_v_reg;
    logic [aus_pkg::QLO_W-1:0]        e_est_reg;
    logic [aus_pkg::TS_W-1:0]         f_ts_reg;

    logic [44:0]                      hi_mult;
    logic [aus_pkg::PROD_HI_W-1:0]    hi_sub, hi_rem;
    logic                             hi_corr;
    logic [aus_pkg::QHI_W-1:0]        hi_q;
    logic [63:0]                      lo_mult;
    logic [31:0]                      lo_sub, lo_rem;
    logic [aus_pkg::QLO_W-1:0]        lo_q;
    logic [34:0]                      q_full;
    logic [aus_pkg::TS_W-1:0]         ts_sat;

    assign en_f     = !f_valid_reg || m_ready;
    assign en_e     = !e_valid_reg || en_f;
    assign en_d     = !d_valid_reg || en_e;
    assign en_c     = !c_valid_reg || en_d;
    assign in_ready = en_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else begin
            if (en_c) c_valid_reg <= in_valid;
            if (en_d) d_valid_reg <= c_valid_reg;
            if (en_e) e_valid_reg <= d_valid_reg;
            if (en_f) f_valid_reg <= e_valid_reg;
        end
    end

    // high part estimate of product / 1000
    assign hi_mult = {23'b0, in_prod[aus_pkg::PROD_W-1:aus_pkg::PROD_LO_W]} *
                     {22'b0, aus_pkg::RECIP_HI};

    always_ff @(posedge aclk) begin
        if (en_c) begin
            c_info_reg <= in_info;
            c_est_reg  <= hi_mult[44:32];
            c_xh_reg   <= in_prod[aus_pkg::PROD_W-1:aus_pkg::PROD_LO_W];
            c_xl_reg   <= in_prod[aus_pkg::PROD_LO_W-1:0];
        end
    end

    // estimate is exact or one low
    assign hi_sub  = c_xh_reg - aus_pkg::PROD_HI_W'(c_est_reg * aus_pkg::PROD_HI_W'(aus_pkg::DIV_BY));
    assign hi_corr = hi_sub >= aus_pkg::PROD_HI_W'(aus_pkg::DIV_BY);
    assign hi_rem  = hi_corr ? hi_sub - aus_pkg::PROD_HI_W'(aus_pkg::DIV_BY) : hi_sub;
    assign hi_q    = hi_corr ? c_est_reg + aus_pkg::QHI_W'(1) : c_est_reg;

    always_ff @(posedge aclk) begin
        if (en_d) begin
            d_info_reg <= c_info_reg;
            d_qh_reg   <= hi_q;
            d_v_reg    <= {hi_rem[aus_pkg::REM_W-1:0], c_xl_reg};
        end
    end

    assign lo_mult = 64'(d_v_reg) * 64'(aus_pkg::RECIP_LO);

    always_ff @(posedge aclk) begin
        if (en_e) begin
            e_info_reg <= d_info_reg;
            e_qh_reg   <= d_qh_reg;
            e_v_reg    <= d_v_reg;
            e_est_reg  <= lo_mult[62:41];
        end
    end

    assign lo_sub = e_v_reg - 32'(32'(e_est_reg) * 32'(aus_pkg::DIV_BY));
    assign lo_rem = lo_sub;
    assign lo_q   = (lo_rem >= 32'(aus_pkg::DIV_BY)) ? e_est_reg + aus_pkg::QLO_W'(1)
                                                     : e_est_reg;
    assign q_full = {e_qh_reg, 22'b0} + 35'(lo_q);
    assign ts_sat = (q_full[34:32] != 3'd0) ? '1 : q_full[31:0];

    always_ff @(posedge aclk) begin
        if (en_f) begin
            f_info_reg <= e_info_reg;
            f_ts_reg   <= e_info_reg.frame_valid ? ts_sat : '0;
        end
    end

    assign m_valid         = f_valid_reg;
    assign m_frame_valid   = f_info_reg.frame_valid;
    assign m_frame_length  = f_info_reg.frame_length;
    assign m_frame_number  = f_info_reg.frame_number;
    assign m_timestamp_ms  = f_ts_reg;
    assign m_end_of_stream = f_info_reg.end_of_stream;

endmodule

// File: sv/annexb_access_unit_splitter_unit.sv
// Splits an H.264 Annex B byte stream into access units. One byte is accepted per clock,
// sustained, as long as results are taken; each byte passes an input register where its
// start-code scan and frame bookkeeping are done combinationally, and a frame result then
// runs through four stages that form frame_number * frame_period_us / 1000 (reciprocal
// multiplies stand in for the divide). m_ready low backs the pipeline up and finally drops
// s_ready. Bytes ahead of the first start code are discarded; the byte flagged last yields
// a result with end_of_stream set and drops any unfinished frame. frame_period_us sits at
// APB address 0.
module annexb_access_unit_splitter_unit #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aus_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [aus_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [aus_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [aus_pkg::DATA_W-1:0]        s_data_byte,
    input  logic                              s_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_frame_valid,
    output logic [aus_pkg::LEN_W-1:0]         m_frame_length,
    output logic [aus_pkg::NUM_W-1:0]         m_frame_number,
    output logic [aus_pkg::TS_W-1:0]          m_timestamp_ms,
    output logic                              m_end_of_stream
);

    logic [aus_pkg::PERIOD_W-1:0] frame_period_us;
    logic                         res_valid;
    logic                         res_ready;
    aus_pkg::result_info_t        res_info;
    logic [aus_pkg::PROD_W-1:0]   res_prod;

    aus_cfg u_cfg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .frame_period_us (frame_period_us)
    );

    aus_scan #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_scan (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last          (s_last),
        .frame_period_us (frame_period_us),
        .out_valid       (res_valid),
        .out_ready       (res_ready),
        .out_info        (res_info),
        .out_prod        (res_prod)
    );

    aus_ts_pipe u_ts_pipe (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (res_valid),
        .in_ready        (res_ready),
        .in_info         (res_info),
        .in_prod         (res_prod),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_valid   (m_frame_valid),
        .m_frame_length  (m_frame_length),
        .m_frame_number  (m_frame_number),
        .m_timestamp_ms  (m_timestamp_ms),
        .m_end_of_stream (m_end_of_stream)
    );

endmodule

// File: test/tb_annexb_access_unit_splitter_unit.sv
module tb_annexb_access_unit_splitter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import aus_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 120;
    localparam int PHASE_BYTES = 200;
    localparam int DRAIN_WAIT  = 10;
    localparam int NUM_PHASES  = 6;
    localparam int PLAN_LEN    = 29;

    localparam logic [LEN_W-1:0]      SPAN_MAX    = 24'hFFFFFF;
    localparam logic [APB_ADDR_W-1:0] ADDR_PERIOD = {REG_FRAME_PERIOD, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

    typedef struct packed {
        logic              frame_valid;
        logic [LEN_W-1:0]  frame_length;
        logic [NUM_W-1:0]  frame_number;
        logic [TS_W-1:0]   timestamp_ms;
        logic              end_of_stream;
    } frame_res_t;

    typedef struct packed {
        logic [DATA_W-1:0] b;
        logic              l;
        logic              typed;
        frame_res_t        res;
    } plan_row_t;

    localparam frame_res_t NO_RES   = '{1'b0, 24'd0, 24'd0, 32'd0, 1'b0};
    localparam frame_res_t EOS_ONLY = '{1'b0, 24'd0, 24'd0, 32'd0, 1'b1};

    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{8'hFF, 1'b1, 1'b1, EOS_ONLY},  // one-byte stream
        '{8'hAB, 1'b0, 1'b0, NO_RES},    // junk ahead of first start code
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'h65, 1'b0, 1'b0, NO_RES},    // IDR opens frame 0
        '{8'h88, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'h06, 1'b0, 1'b0, NO_RES},    // SEI, not a boundary
        '{8'h80, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'h41, 1'b0, 1'b0, NO_RES},    // slice with first_mb != 0
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},    // 4-byte start code
        '{8'h25, 1'b0, 1'b0, NO_RES},
        '{8'h80, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'h21, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b1, 1'b0, NO_RES},    // boundary on the last byte
        '{8'h00, 1'b1, 1'b1, EOS_ONLY}
    };

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   psel        = 1'b0;
    logic                   penable     = 1'b0;
    logic                   pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr       = '0;
    logic [APB_DATA_W-1:0]  pwdata      = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_valid     = 1'b0;
    logic                   s_ready;
    logic [DATA_W-1:0]      s_data_byte = '0;
    logic                   s_last      = 1'b0;
    logic                   m_valid;
    logic                   m_ready     = 1'b0;
    logic                   m_frame_valid;
    logic [LEN_W-1:0]       m_frame_length;
    logic [NUM_W-1:0]       m_frame_number;
    logic [TS_W-1:0]        m_timestamp_ms;
    logic                   m_end_of_stream;

    // splitter shadow state
    logic [DATA_W-1:0]   win_bytes [0:WIN_DEPTH-1];
    logic [2:0]          win_fill;
    logic [LEN_W-1:0]    span_len;
    bit                  in_frame;
    logic [1:0]          skip_left;
    logic [NUM_W-1:0]    frame_idx;
    bit                  last_scanned;
    logic [PERIOD_W-1:0] period_cfg;

    frame_res_t pending_frames [$];

    bit idle_on     = 1'b0;
    bit stall_arm   = 1'b0;
    bit stall_taken = 1'b0;
    int hold_left   = 0;
    int bytes_sent      = 0;
    int streams_done    = 0;
    int results_checked = 0;
    int error_count     = 0;
    int cycle_count     = 0;
    int pause_after     = -1;

    annexb_access_unit_splitter_unit dut (.*);

    always #5ns aclk = ~aclk;

    function automatic void clear_split_state();
        for (int j = 0; j < WIN_DEPTH; j++) win_bytes[j] = '0;
        win_fill     = '0;
        span_len     = '0;
        in_frame     = 1'b0;
        skip_left    = '0;
        frame_idx    = '0;
        last_scanned = 1'b0;
    endfunction

    function automatic bit predict_split(input logic [DATA_W-1:0] c, input logic l,
                                         output frame_res_t r);
        logic [2:0]        nfill;
        logic [DATA_W-1:0] nal;
        logic [LEN_W-1:0]  len;
        logic [63:0]       ts;
        bit                scanned;
        bit                four;
        bit                hit;
        r     = NO_RES;
        hit   = 1'b0;
        nfill = (win_fill < FILL_MAX) ? win_fill + 3'd1 : FILL_MAX;
        if (nfill >= WIN_READY) begin
            scanned = (skip_left == 2'd0);
            if (in_frame && span_len < SPAN_MAX) span_len = span_len + 1'b1;
            if (skip_left != 2'd0) begin
                skip_left = skip_left - 2'd1;
            end else if (win_bytes[1] == 8'h00 && win_bytes[2] == 8'h00 &&
                         win_bytes[3] == 8'h01) begin
                four = last_scanned && nfill == FILL_MAX && win_bytes[0] == 8'h00;
                nal  = win_bytes[4] & NAL_TYPE_MASK;
                if (!in_frame) begin
                    in_frame = 1'b1;
                    span_len = four ? 24'd1 : 24'd0;
                end else if (nal >= 8'd1 && nal <= 8'd5 && c[DATA_W-1]) begin
                    len = span_len;
                    if (four && len < SPAN_MAX) len = len - 1'b1;
                    ts = (64'(frame_idx) * 64'(period_cfg)) / 64'(DIV_BY);
                    if (ts > 64'hFFFF_FFFF) ts = 64'hFFFF_FFFF;
                    r.frame_valid  = 1'b1;
                    r.frame_length = len;
                    r.frame_number = frame_idx;
                    r.timestamp_ms = ts[TS_W-1:0];
                    hit            = 1'b1;
                    frame_idx      = frame_idx + 1'b1;
                    span_len       = four ? 24'd1 : 24'd0;
                end
                skip_left = four ? 2'd1 : 2'd2;
            end
            last_scanned = scanned;
        end
        for (int j = 0; j < WIN_DEPTH - 1; j++) win_bytes[j] = win_bytes[j+1];
        win_bytes[WIN_DEPTH-1] = c;
        win_fill = nfill;
        if (l) begin
            r.end_of_stream = 1'b1;
            hit = 1'b1;
            clear_split_state();
        end
        return hit;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < 100) $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_frames.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic feed_byte(input logic [DATA_W-1:0] b, input logic l,
                             input logic typed, input frame_res_t typed_res);
        frame_res_t r;
        bit         hit;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last      <= l;
        do @(posedge aclk); while (!s_ready);
        hit = predict_split(b, l, r);
        if (typed) pending_frames.push_back(typed_res);
        else if (hit) pending_frames.push_back(r);
        bytes_sent++;
        if (l) streams_done++;
        if (bytes_sent == pause_after) drain_results();
    endtask

    task automatic feed(input logic [DATA_W-1:0] b, input logic l);
        feed_byte(b, l, 1'b0, NO_RES);
    endtask

    function automatic logic [DATA_W-1:0] stream_byte();
        case ($urandom_range(0, 7))
            0, 1:    return 8'h00;
            2:       return 8'h01;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly well-formed NAL sequences, some pure noise
    task automatic random_stream();
        int                nals;
        int                plen;
        bit                tail_hit;
        logic [DATA_W-1:0] hdr;
        logic [DATA_W-1:0] nxt;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(0, 40)) feed(stream_byte(), 1'b0);
            feed(stream_byte(), 1'b1);
        end else begin
            repeat ($urandom_range(0, 3)) feed(8'($urandom_range(0, 255)), 1'b0);
            nals     = $urandom_range(1, 8);
            tail_hit = $urandom_range(0, 1);
            for (int k = 0; k < nals; k++) begin
                if ($urandom_range(0, 1) != 0) feed(8'h00, 1'b0);
                feed(8'h00, 1'b0);
                feed(8'h00, 1'b0);
                feed(8'h01, 1'b0);
                hdr = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) != 0) hdr[3:0] = 4'($urandom_range(1, 5));
                feed(hdr, 1'b0);
                nxt = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) != 0) nxt[DATA_W-1] = 1'b1;
                if (tail_hit && k == nals - 1) begin
                    feed(nxt, 1'b1);
                end else begin
                    feed(nxt, 1'b0);
                    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60)
                                                        : $urandom_range(0, 6);
                    repeat (plen) feed(stream_byte(), 1'b0);
                end
            end
            if (!tail_hit) feed(stream_byte(), 1'b1);
        end
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_PERIOD) period_cfg = data[PERIOD_W-1:0];
    endtask

    task automatic check_period();
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_PERIOD;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== APB_DATA_W'(period_cfg))
            report_error($sformatf("frame_period_us read %0d, expected %0d",
                                   prdata, period_cfg));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result sink: random short stalls plus one long hold-off
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (stall_arm && !stall_taken) begin
            stall_taken <= 1'b1;
            hold_left   <= LONG_HOLD - 1;
            m_ready     <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            hold_left <= $urandom_range(0, 2);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        frame_res_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (pending_frames.size() == 0) begin
                report_error("result transfer with nothing expected");
            end else begin
                want = pending_frames.pop_front();
                if (m_frame_valid !== want.frame_valid)
                    report_error($sformatf("frame_valid %0b, expected %0b",
                                           m_frame_valid, want.frame_valid));
                if (m_frame_length !== want.frame_length)
                    report_error($sformatf("frame_length %0d, expected %0d",
                                           m_frame_length, want.frame_length));
                if (m_frame_number !== want.frame_number)
                    report_error($sformatf("frame_number %0d, expected %0d",
                                           m_frame_number, want.frame_number));
                if (m_timestamp_ms !== want.timestamp_ms)
                    report_error($sformatf("timestamp_ms %0d, expected %0d (frame %0d)",
                                           m_timestamp_ms, want.timestamp_ms,
                                           want.frame_number));
                if (m_end_of_stream !== want.end_of_stream)
                    report_error($sformatf("end_of_stream %0b, expected %0b",
                                           m_end_of_stream, want.end_of_stream));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int                  target;
        logic [PERIOD_W-1:0] per;
        clear_split_state();
        period_cfg = PERIOD_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        check_period();
        idle_on <= 1'b1;
        for (int i = 0; i < PLAN_LEN; i++)
            feed_byte(PLAN[i].b, PLAN[i].l, PLAN[i].typed, PLAN[i].res);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            if (p == 3) begin
                apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
                check_period();
            end
            case (p)
                0:       per = 20'd1;
                1:       per = 20'd1000000;
                2:       per = 20'd0;
                3:       per = 20'hFFFFF;
                4:       per = 20'($urandom_range(1, 1000000));
                default: per = PERIOD_RESET;
            endcase
            apb_write(ADDR_PERIOD, APB_DATA_W'(per));
            check_period();
            idle_on <= (p != NUM_PHASES - 1);
            if (p == 1) stall_arm <= 1'b1;
            if (p == 3) pause_after = bytes_sent + 90;
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) random_stream();
        end
        drain_results();

        $display("Fed %0d bytes in %0d streams, checked %0d results over %0d period settings",
                 bytes_sent, streams_done, results_checked, NUM_PHASES + 1);
        $display("Run included a long output stall, a drained pause and an unmapped write");
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
